FILE: sv/bprm_pkg.sv
// Shared constants and types for the block peak/RMS meter.
package bprm_pkg;

   // Width of the configuration registers and of the result fields.
   localparam int CFG_W = 16;
   localparam int OUT_W = 16;
   localparam int BUS_W = 32;
   localparam int ADDR_W = 3;

   // Register index, taken from the word address bit of the CSR port.
   localparam logic CSR_BLOCK_LENGTH = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] BLOCK_LENGTH_RESET = 16'd1024;
   localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = 16'd512;

   // Closed-block queue between the front and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Back end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_LOAD = 4'b1000
   } back_state_type;

endpackage

FILE: sv/bprm_req_if.sv
// Sample channel interface: valid/ready handshake with one PCM sample per beat.
interface bprm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          stream_end;

   modport source (output valid, output sample, output stream_end, input ready);
   modport sink (input valid, input sample, input stream_end, output ready);
endinterface

FILE: sv/bprm_rsp_if.sv
// Result channel interface: valid/ready handshake with one block result per beat.
interface bprm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bprm_pkg::OUT_W-1:0] peak;
   logic [bprm_pkg::OUT_W-1:0] rms;
   logic [bprm_pkg::OUT_W-1:0] block_index;
   logic                        final_block;

   modport source (output valid, output peak, output rms, output block_index,
                   output final_block, input ready);
   modport sink (input valid, input peak, input rms, input block_index,
                 input final_block, output ready);
endinterface

FILE: sv/block_peak_rms_meter_top.sv
// Top level of the block peak/RMS meter: CSR port, front end, block queue and back end.
//
//   channel   dir   handshake          payload per beat
//   req_bus   in    valid/ready        sample (signed), stream_end
//   rsp_bus   out   valid/ready        peak, rms, block_index, final_block
//   csr_*     in    APB write/read     block_length @ 0x0, block_count @ 0x4
//
// The front takes one sample per cycle while no closed block waits for queue room;
// a sample passes a pipeline register before it enters its accumulator. The back
// end makes one quotient bit and then one root bit per cycle in a single sequencer.
// Up to four closed blocks wait in the queue; req_bus.ready is low during that wait.
// Reset is synchronous and clears the counters, queue and sequencer; no clearing pass.
// A result waiting on rsp_bus does not stop the back end from starting the next block.
module block_peak_rms_meter_top #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   bprm_req_if.sink                      req_bus,
   bprm_rsp_if.source                    rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bprm_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [bprm_pkg::BUS_W-1:0]    csr_pwdata,
   output logic [bprm_pkg::BUS_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   // Square sum width: count times the largest square, capped at 64 with saturation.
   localparam int SUM_RAW = COUNT_BITS + 2 * SAMPLE_BITS - 2;
   localparam int SUM_W = (SUM_RAW > 64) ? 64 : SUM_RAW;
   localparam int ENTRY_W = SAMPLE_BITS + SUM_W + 2 * COUNT_BITS + 1;
   localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

   logic [bprm_pkg::CFG_W-1:0] block_length_ff, block_count_ff;
   logic                       csr_write;

   logic [31:0]               len_wide, cnt_wide;
   logic [COUNT_BITS-1:0]     len, cnt;

   logic                   push_valid, push_ready, pop_valid, pop_ready;
   logic [SAMPLE_BITS-1:0] push_peak, pop_peak;
   logic [SUM_W-1:0]       push_sum, pop_sum;
   logic [COUNT_BITS-1:0]  push_count, push_index, pop_count, pop_index;
   logic                   push_final, pop_final;
   logic [ENTRY_W-1:0]     push_data, pop_data;

   // Write at the access cycle; the word address bit picks the register.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= bprm_pkg::BLOCK_LENGTH_RESET;
         block_count_ff <= bprm_pkg::BLOCK_COUNT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == bprm_pkg::CSR_BLOCK_LENGTH) begin
            block_length_ff <= csr_pwdata[bprm_pkg::CFG_W-1:0];
         end else begin
            block_count_ff <= csr_pwdata[bprm_pkg::CFG_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == bprm_pkg::CSR_BLOCK_COUNT)
                       ? bprm_pkg::BUS_W'(block_count_ff)
                       : bprm_pkg::BUS_W'(block_length_ff);

   // Clamp the settings to the counter range; a zero block length acts as one.
   always_comb begin
      len_wide = 32'(block_length_ff);
      cnt_wide = 32'(block_count_ff);
      if (len_wide > CNT_MAX) begin
         len_wide = CNT_MAX;
      end
      if (len_wide == 32'd0) begin
         len_wide = 32'd1;
      end
      if (cnt_wide > CNT_MAX) begin
         cnt_wide = CNT_MAX;
      end
   end

   assign len = len_wide[COUNT_BITS-1:0];
   assign cnt = cnt_wide[COUNT_BITS-1:0];

   bprm_front #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .SUM_W      (SUM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .len       (len),
      .cnt       (cnt),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_peak (push_peak),
      .push_sum  (push_sum),
      .push_count(push_count),
      .push_index(push_index),
      .push_final(push_final)
   );

   // Pack one closed block per queue entry.
   assign push_data = {push_peak, push_sum, push_count, push_index, push_final};
   assign {pop_peak, pop_sum, pop_count, pop_index, pop_final} = pop_data;

   bprm_queue #(
      .DATA_W(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   bprm_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .SUM_W      (SUM_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_peak (pop_peak),
      .pop_sum  (pop_sum),
      .pop_count(pop_count),
      .pop_index(pop_index),
      .pop_final(pop_final),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: sv/bprm_front.sv
// Front end: classifies samples against the block counters and accumulates peak and square sum.
module bprm_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS = 16,
   parameter int SUM_W = 46
) (
   input  logic                  clock,
   input  logic                  reset,
   bprm_req_if.sink              req_bus,
   input  logic [COUNT_BITS-1:0] len,
   input  logic [COUNT_BITS-1:0] cnt,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [SAMPLE_BITS-1:0] push_peak,
   output logic [SUM_W-1:0]      push_sum,
   output logic [COUNT_BITS-1:0] push_count,
   output logic [COUNT_BITS-1:0] push_index,
   output logic                  push_final
);

   localparam int SQ_W = 2 * SAMPLE_BITS;

   logic [COUNT_BITS-1:0]  samples_ff, samples_in;
   logic [COUNT_BITS-1:0]  blocks_ff, blocks_in;

   logic                   p_valid_ff, p_valid_in;
   logic [SAMPLE_BITS-1:0] p_mag_ff;
   logic [SQ_W-1:0]        p_sq_ff;
   logic                   p_start_ff, p_close_ff, p_final_ff;
   logic [COUNT_BITS-1:0]  p_count_ff, p_index_ff;

   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   logic                   advance, accept, ignore, close, fin;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SQ_W-1:0]        mag_ext;
   logic [COUNT_BITS:0]    n_next, done_next;
   logic [SUM_W:0]         sum_add;

   // Hold the stage while a closed block waits for queue room.
   assign advance = !p_valid_ff || !p_close_ff || push_ready;
   assign req_bus.ready = advance;
   assign accept = req_bus.valid && advance;

   assign ignore = blocks_ff >= cnt;
   assign n_next = {1'b0, samples_ff} + {{COUNT_BITS{1'b0}}, 1'b1};
   assign done_next = {1'b0, blocks_ff} + {{COUNT_BITS{1'b0}}, 1'b1};
   assign close = (n_next >= {1'b0, len}) || req_bus.stream_end;
   assign fin = req_bus.stream_end || (done_next == {1'b0, cnt});

   assign mag = req_bus.sample[SAMPLE_BITS-1] ? (~req_bus.sample + 1'b1) : req_bus.sample;
   assign mag_ext = SQ_W'(mag);

   always_comb begin
      samples_in = samples_ff;
      blocks_in = blocks_ff;
      if (accept) begin
         if (ignore) begin
            if (req_bus.stream_end) begin
               samples_in = '0;
               blocks_in = '0;
            end
         end else if (close) begin
            samples_in = '0;
            blocks_in = req_bus.stream_end ? '0 : done_next[COUNT_BITS-1:0];
         end else begin
            samples_in = n_next[COUNT_BITS-1:0];
         end
      end
   end

   assign p_valid_in = accept && !ignore;

   // Accumulate; a block start reloads from the incoming sample.
   assign sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(p_sq_ff);

   always_comb begin
      if (p_start_ff) begin
         peak_in = p_mag_ff;
         sum_in = SUM_W'(p_sq_ff);
      end else begin
         peak_in = (p_mag_ff > peak_ff) ? p_mag_ff : peak_ff;
         sum_in = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      end
   end

   assign push_valid = p_valid_ff && p_close_ff;
   assign push_peak = peak_in;
   assign push_sum = sum_in;
   assign push_count = p_count_ff;
   assign push_index = p_index_ff;
   assign push_final = p_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= '0;
         blocks_ff <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         samples_ff <= samples_in;
         blocks_ff <= blocks_in;
         if (advance) begin
            p_valid_ff <= p_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_mag_ff <= mag;
         p_sq_ff <= mag_ext * mag_ext;
         p_start_ff <= (samples_ff == '0);
         p_close_ff <= close;
         p_final_ff <= fin;
         p_count_ff <= n_next[COUNT_BITS-1:0];
         p_index_ff <= blocks_ff;
      end
      if (p_valid_ff && advance) begin
         peak_ff <= peak_in;
         sum_ff <= sum_in;
      end
   end

endmodule

FILE: sv/bprm_queue.sv
// Short FIFO of closed blocks between the front and the back end.
module bprm_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0]                entry_ff [bprm_pkg::QUEUE_DEPTH];
   logic [bprm_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bprm_pkg::QUEUE_CNT_W-1:0] fill_ff;
   logic                             do_push, do_pop;

   assign push_ready = fill_ff != bprm_pkg::QUEUE_CNT_W'(bprm_pkg::QUEUE_DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/bprm_back.sv
// Back end: bit-serial mean (sum / count) and digit-serial square root, then result register.
module bprm_back #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS = 16,
   parameter int SUM_W = 46
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [SAMPLE_BITS-1:0] pop_peak,
   input  logic [SUM_W-1:0]       pop_sum,
   input  logic [COUNT_BITS-1:0]  pop_count,
   input  logic [COUNT_BITS-1:0]  pop_index,
   input  logic                   pop_final,
   bprm_rsp_if.source             rsp_bus
);

   localparam int RW = (SUM_W + 1) / 2;
   localparam int XW = 2 * RW;
   localparam int STEP_W = $clog2(SUM_W + 1);

   bprm_pkg::back_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [COUNT_BITS-1:0]  index_ff, divisor_ff, rem_ff;
   logic                   final_ff;
   logic [SUM_W-1:0]       quo_ff;
   logic [XW-1:0]          x_ff;
   logic [RW-1:0]          root_ff;
   logic [RW+1:0]          rrem_ff;
   logic [STEP_W-1:0]      step_ff;

   logic                   out_valid_ff;
   logic [bprm_pkg::OUT_W-1:0] out_peak_ff, out_rms_ff, out_index_ff;
   logic                   out_final_ff;

   logic [COUNT_BITS:0]    div_cand, div_diff;
   logic                   div_ge;
   logic [SUM_W-1:0]       quo_next;
   logic [RW+3:0]          root_cand, root_trial, root_diff;
   logic                   root_ge;
   logic                   out_free, load_out;

   // One quotient bit per cycle.
   assign div_cand = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge = div_cand >= {1'b0, divisor_ff};
   assign div_diff = div_cand - {1'b0, divisor_ff};
   assign quo_next = {quo_ff[SUM_W-2:0], div_ge};

   // One root bit per cycle from the top two radicand bits.
   assign root_cand = {rrem_ff, x_ff[XW-1:XW-2]};
   assign root_trial = (RW + 4)'({root_ff, 2'b01});
   assign root_ge = root_cand >= root_trial;
   assign root_diff = root_cand - root_trial;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign load_out = (state_ff == bprm_pkg::ST_LOAD) && out_free;
   assign pop_ready = state_ff == bprm_pkg::ST_IDLE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bprm_pkg::ST_IDLE: begin
            if (pop_valid) begin
               state_in = bprm_pkg::ST_DIV;
            end
         end
         bprm_pkg::ST_DIV: begin
            if (step_ff == '0) begin
               state_in = bprm_pkg::ST_ROOT;
            end
         end
         bprm_pkg::ST_ROOT: begin
            if (step_ff == '0) begin
               state_in = bprm_pkg::ST_LOAD;
            end
         end
         bprm_pkg::ST_LOAD: begin
            if (out_free) begin
               state_in = bprm_pkg::ST_IDLE;
            end
         end
         default: state_in = bprm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bprm_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bprm_pkg::ST_IDLE: begin
            peak_ff <= pop_peak;
            index_ff <= pop_index;
            final_ff <= pop_final;
            divisor_ff <= pop_count;
            quo_ff <= pop_sum;
            rem_ff <= '0;
            step_ff <= STEP_W'(SUM_W - 1);
         end
         bprm_pkg::ST_DIV: begin
            quo_ff <= quo_next;
            rem_ff <= div_ge ? div_diff[COUNT_BITS-1:0] : div_cand[COUNT_BITS-1:0];
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               x_ff <= XW'(quo_next);
               root_ff <= '0;
               rrem_ff <= '0;
               step_ff <= STEP_W'(RW - 1);
            end
         end
         bprm_pkg::ST_ROOT: begin
            x_ff <= {x_ff[XW-3:0], 2'b00};
            root_ff <= {root_ff[RW-2:0], root_ge};
            rrem_ff <= root_ge ? root_diff[RW+1:0] : root_cand[RW+1:0];
            step_ff <= step_ff - 1'b1;
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
      if (load_out) begin
         out_peak_ff <= bprm_pkg::OUT_W'(peak_ff);
         out_rms_ff <= bprm_pkg::OUT_W'(root_ff);
         out_index_ff <= bprm_pkg::OUT_W'(index_ff);
         out_final_ff <= final_ff;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.peak = out_peak_ff;
   assign rsp_bus.rms = out_rms_ff;
   assign rsp_bus.block_index = out_index_ff;
   assign rsp_bus.final_block = out_final_ff;

endmodule

FILE: tb/bprm_level_checker.sv
// Block level checker: follows the CSR writes and accepted samples, predicts each block result.
module bprm_level_checker (
   input  logic                        clock,
   input  logic                        reset,
   bprm_req_if                         req_mon,
   bprm_rsp_if                         rsp_mon,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bprm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [bprm_pkg::BUS_W-1:0]  csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          pending,
   output int                          metered,
   output int                          blocks_checked,
   output int                          finals_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [bprm_pkg::OUT_W-1:0] peak;
      logic [bprm_pkg::OUT_W-1:0] rms;
      logic [bprm_pkg::OUT_W-1:0] block_index;
      logic                       final_block;
   } block_level_type;

   logic [bprm_pkg::CFG_W-1:0] block_length;
   logic [bprm_pkg::CFG_W-1:0] block_count;
   int unsigned      fill;
   int unsigned      peak_hold;
   int unsigned      blocks_done;
   longint unsigned  energy;
   block_level_type  expected_levels[$];
   int               fails;
   int               metered_n;
   int               checked_n;
   int               finals_n;

   // Build the root one bit at a time, keeping a bit if its square still fits.
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   task automatic clear_block();
      fill = 0;
      peak_hold = 0;
      energy = 0;
   endtask

   task automatic meter_sample(input int sval, input logic last);
      int unsigned     span;
      int unsigned     mag;
      block_level_type lvl;
      span = (block_length == 0) ? 1 : block_length;
      // Past the block budget: drop samples, a stream end restarts the meter.
      if (blocks_done >= block_count) begin
         if (last) begin
            clear_block();
            blocks_done = 0;
         end
         return;
      end
      mag = (sval < 0) ? -sval : sval;
      metered_n++;
      fill++;
      if (mag > peak_hold) peak_hold = mag;
      energy += mag * mag;
      if (fill >= span || last) begin
         lvl.peak        = peak_hold[bprm_pkg::OUT_W-1:0];
         lvl.rms         = bprm_pkg::OUT_W'(floor_root(energy / fill));
         lvl.block_index = blocks_done[bprm_pkg::OUT_W-1:0];
         lvl.final_block = last || (blocks_done + 1 == block_count);
         expected_levels = {expected_levels, lvl};
         clear_block();
         blocks_done = last ? 0 : blocks_done + 1;
      end
   endtask

   task automatic compare_field(input string name, input logic [bprm_pkg::OUT_W-1:0] want,
                                input logic [bprm_pkg::OUT_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      block_level_type want;
      if (reset) begin
         block_length = bprm_pkg::BLOCK_LENGTH_RESET;
         block_count  = bprm_pkg::BLOCK_COUNT_RESET;
         clear_block();
         blocks_done = 0;
         expected_levels.delete();
         fails = 0;
         metered_n = 0;
         checked_n = 0;
         finals_n = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == bprm_pkg::CSR_BLOCK_LENGTH)
               block_length = csr_pwdata[bprm_pkg::CFG_W-1:0];
            else
               block_count = csr_pwdata[bprm_pkg::CFG_W-1:0];
         end
         // Check the result beat before the sample beat so a stray result is never masked.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_levels.size() == 0) begin
               $error("result beat with no block pending: peak %0d rms %0d index %0d final %0b",
                      rsp_mon.peak, rsp_mon.rms, rsp_mon.block_index, rsp_mon.final_block);
               fails++;
            end else begin
               want = expected_levels.pop_front();
               compare_field("peak", want.peak, rsp_mon.peak);
               compare_field("rms", want.rms, rsp_mon.rms);
               compare_field("block_index", want.block_index, rsp_mon.block_index);
               compare_field("final_block", want.final_block, rsp_mon.final_block);
               checked_n++;
               if (want.final_block) finals_n++;
            end
         end
         if (req_mon.valid && req_mon.ready) meter_sample(req_mon.sample, req_mon.stream_end);
      end
      fail_count     <= fails;
      pending        <= expected_levels.size();
      metered        <= metered_n;
      blocks_checked <= checked_n;
      finals_checked <= finals_n;
   end
endmodule

FILE: tb/tb.sv
// Testbench top for the block peak/RMS meter: clock, reset, stimulus, CSR setup and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int METERED_TARGET = 1800;
   localparam int DRAIN_CYCLES   = 100;   // trailing wait so that dropped samples have finished
   localparam int HOLD_CYCLES    = 300;   // long result hold-off, fills the block queue

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [bprm_pkg::ADDR_W-1:0] csr_paddr;
   logic [bprm_pkg::BUS_W-1:0]  csr_pwdata;
   logic [bprm_pkg::BUS_W-1:0]  csr_prdata;
   logic                        csr_pready;

   int fail_count;
   int pending;
   int metered;
   int blocks_checked;
   int finals_checked;
   int settings_used;

   // Idling controls: steady phases drop all gaps on that side.
   bit tx_steady;
   bit rx_steady;
   bit hold_req;
   bit hold_served;

   bprm_req_if #(.SAMPLE_BITS(16)) req_bus();
   bprm_rsp_if                     rsp_bus();

   block_peak_rms_meter_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bprm_level_checker level_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending        (pending),
      .metered        (metered),
      .blocks_checked (blocks_checked),
      .finals_checked (finals_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop if the run does not finish.
   initial begin
      #20ms;
      $display("tb failed");
      $finish;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sample mix: full-scale extremes, values near zero, and plain random words.
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(0, 31) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall_left;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_served) begin
            // Hold ready low and count the stretch here while the sender keeps pushing.
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Offer one sample beat and hold it until the block takes it. Valid stays high
   // into the next beat when there is no gap, so it is never lowered and raised at once.
   task automatic send_sample(input logic signed [15:0] value, input logic last);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample     <= value;
      req_bus.stream_end <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // A stream of random samples; a stray stream end now and then breaks it early.
   task automatic send_stream(input int n, input bit close);
      logic last;
      for (int i = 0; i < n; i++) begin
         last = (close && i == n - 1) || ($urandom_range(0, 59) == 0);
         send_sample(pick_sample(), last);
      end
   endtask

   // Drop valid, wait for every pending block result, then let trailing work finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, then back to idle. Upper data bits are noise.
   task automatic write_reg(input logic idx, input logic [bprm_pkg::CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= bprm_pkg::ADDR_W'({idx, 2'b00});
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [bprm_pkg::CFG_W-1:0] len,
                            input logic [bprm_pkg::CFG_W-1:0] cnt);
      write_reg(bprm_pkg::CSR_BLOCK_LENGTH, len);
      write_reg(bprm_pkg::CSR_BLOCK_COUNT, cnt);
      settings_used++;
   endtask

   initial begin
      int                         base;
      int                         r;
      int                         n;
      longint                     reach;
      logic [bprm_pkg::CFG_W-1:0] len;
      logic [bprm_pkg::CFG_W-1:0] cnt;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.sample     = '0;
      req_bus.stream_end = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      settings_used      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings (1024 x 512): extremes and near-zero values, then a stream
      // end that closes a short partial block.
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shffff, 1'b0);
      send_sample(16'sh0001, 1'b0);
      send_sample(16'shfffe, 1'b1);
      settle();

      // Zero block length acts as one. Budget of three blocks: the third is final,
      // then samples drop, a stream end while dropping yields nothing, and a fresh
      // stream starts at block zero.
      configure(16'd0, 16'd3);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh0005, 1'b0);
      send_sample(16'sh0007, 1'b0);
      send_sample(16'shfff9, 1'b0);
      send_sample(16'sh0009, 1'b1);
      send_sample(16'sh0064, 1'b0);
      settle();

      // Zero block count: everything drops, stream end included.
      configure(16'd5, 16'd0);
      send_sample(16'sh0004, 1'b0);
      send_sample(16'shfffc, 1'b0);
      send_sample(16'sh0001, 1'b1);
      settle();

      // Largest length and count: only a stream end can close the block.
      configure(16'hffff, 16'hffff);
      send_sample(16'sh1234, 1'b0);
      send_sample(16'sh8001, 1'b0);
      send_sample(16'sh7ffe, 1'b0);
      send_sample(16'shc000, 1'b1);
      settle();

      // Stream end landing on the last sample of a full block.
      configure(16'd3, 16'hffff);
      send_sample(16'sh0100, 1'b0);
      send_sample(16'shff00, 1'b0);
      send_sample(16'sh2000, 1'b1);
      settle();

      // Back-pressure: one-sample blocks at full rate while results are held off,
      // so the block queue fills and the sample input stalls.
      configure(16'd1, 16'hffff);
      tx_steady = 1'b1;
      hold_req  = 1'b1;
      send_stream(40, 1'b0);
      tx_steady = 1'b0;
      settle();

      // Random phases: new settings each time, then a few streams shaped to
      // run through whole blocks and into the dropped tail.
      base = metered;
      while (metered < base + METERED_TARGET) begin
         r = $urandom_range(0, 19);
         if (r < 12) len = bprm_pkg::CFG_W'($urandom_range(1, 8));
         else if (r < 17) len = bprm_pkg::CFG_W'($urandom_range(9, 64));
         else if (r < 19) len = bprm_pkg::CFG_W'($urandom_range(65, 400));
         else len = 16'hffff;
         r = $urandom_range(0, 19);
         if (r < 10) cnt = bprm_pkg::CFG_W'($urandom_range(1, 4));
         else if (r < 15) cnt = bprm_pkg::CFG_W'($urandom_range(5, 20));
         else if (r < 18) cnt = 16'hffff;
         else cnt = bprm_pkg::CFG_W'($urandom_range(1, 65535));
         configure(len, cnt);
         tx_steady = ($urandom_range(0, 4) == 0);
         rx_steady = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 3)) begin
            reach = longint'(len) * cnt + 4;
            n = $urandom_range(1, (reach < 80) ? int'(reach) : 80);
            send_stream(n, $urandom_range(0, 4) != 0);
         end
         settle();
      end

      $display("Run covered %0d metered samples over %0d register settings.",
               metered, settings_used);
      $display("Compared %0d block results, %0d of them flagged final.",
               blocks_checked, finals_checked);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
